/* rtl/core/baro_pkg.sv */
package baro_pkg;

   // register map
   typedef logic [2:0] csr_idx_type;

   localparam csr_idx_type CSR_OFFSET_COEFS = 3'd0;
   localparam csr_idx_type CSR_SENS_COEFS   = 3'd1;
   localparam csr_idx_type CSR_TEMP_COEFS   = 3'd2;
   localparam csr_idx_type CSR_SQUARE_COEFS = 3'd3;
   localparam csr_idx_type CSR_CURVE_COEFS  = 3'd4;
   localparam csr_idx_type CSR_OVERSAMPLING = 3'd5;

   localparam logic [31:0] OFFSET_COEFS_RESET = 32'd26804152;
   localparam logic [31:0] SENS_COEFS_RESET   = 32'd3352395749;
   localparam logic [31:0] TEMP_COEFS_RESET   = 32'd2146785905;
   localparam logic [31:0] SQUARE_COEFS_RESET = 32'd405667844;
   localparam logic [31:0] CURVE_COEFS_RESET  = 32'd3724086068;
   localparam logic [1:0]  OVERSAMPLING_RESET = 2'd1;

   // compensation constants
   localparam logic signed [27:0] B6_BIAS    = 28'sd4000;
   localparam logic [11:0]        P_SQ_GAIN  = 12'd3038;
   localparam logic signed [14:0] P_LIN_GAIN = -15'sd7357;
   localparam logic signed [47:0] P_OFFSET   = 48'sd3791;
   localparam logic [15:0]        B7_SCALE   = 16'd50000;
   localparam logic [31:0]        B4_BIAS    = 32'd32768;
   localparam logic [31:0]        B7_HALF    = 32'h8000_0000;

   localparam logic signed [23:0] TEMP_MAX   = 24'sd32767;
   localparam logic signed [23:0] TEMP_MIN   = -24'sd32768;
   localparam logic signed [47:0] PRES_MAX   = 48'sd1048575;

   typedef struct packed {
      logic [15:0] raw_temp;
      logic [18:0] raw_pressure;
   } req_payload_type;

   typedef struct packed {
      logic signed [15:0] temperature_dc;
      logic [19:0]        pressure_pa;
      logic               divide_error;
   } rsp_payload_type;

   typedef struct packed {
      csr_idx_type index;
      logic [31:0] data;
   } csr_payload_type;

   // sideband through the temperature divider
   typedef struct packed {
      logic signed [18:0] x1;
      logic [18:0]        up;
      logic               dzero;
      logic               neg;
   } tdiv_side_type;

   // sideband through the pressure divider
   typedef struct packed {
      logic signed [15:0] temp;
      logic               err;
      logic               hi;
   } pdiv_side_type;

endpackage

/* rtl/core/baro_chan_if.sv */
interface baro_chan_if #(parameter type payload_type = logic) ();
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

/* rtl/core/baro_div.sv */
module baro_div #(
   parameter int NumW  = 27,
   parameter int DenW  = 18,
   parameter int SideW = 1
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             en,
   input  logic             in_vld,
   input  logic [NumW-1:0]  in_num,
   input  logic [DenW-1:0]  in_den,
   input  logic [SideW-1:0] in_side,
   output logic             out_vld,
   output logic [NumW-1:0]  out_quo,
   output logic [SideW-1:0] out_side
);

   // one quotient bit per stage, msb first
   logic             vld_ff  [NumW];
   logic [NumW-1:0]  num_ff  [NumW];
   logic [DenW-1:0]  rem_ff  [NumW];
   logic [DenW-1:0]  den_ff  [NumW];
   logic [SideW-1:0] side_ff [NumW];

   logic [NumW-1:0]  num_in  [NumW];
   logic [DenW-1:0]  rem_in  [NumW];

   always_comb begin
      logic [NumW-1:0] src_num;
      logic [DenW-1:0] src_rem;
      logic [DenW-1:0] src_den;
      logic [DenW:0]   trial;
      for (int k = 0; k < NumW; k++) begin
         if (k == 0) begin
            src_num = in_num;
            src_rem = '0;
            src_den = in_den;
         end else begin
            src_num = num_ff[k-1];
            src_rem = rem_ff[k-1];
            src_den = den_ff[k-1];
         end
         trial = {src_rem, src_num[NumW-1]};
         if (trial >= {1'b0, src_den}) begin
            rem_in[k] = DenW'(trial - {1'b0, src_den});
            num_in[k] = {src_num[NumW-2:0], 1'b1};
         end else begin
            rem_in[k] = trial[DenW-1:0];
            num_in[k] = {src_num[NumW-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < NumW; k++) vld_ff[k] <= 1'b0;
      end else if (en) begin
         vld_ff[0] <= in_vld;
         for (int k = 1; k < NumW; k++) vld_ff[k] <= vld_ff[k-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < NumW; k++) begin
            num_ff[k] <= num_in[k];
            rem_ff[k] <= rem_in[k];
         end
         den_ff[0]  <= in_den;
         side_ff[0] <= in_side;
         for (int k = 1; k < NumW; k++) begin
            den_ff[k]  <= den_ff[k-1];
            side_ff[k] <= side_ff[k-1];
         end
      end
   end

   assign out_vld  = vld_ff[NumW-1];
   assign out_quo  = num_ff[NumW-1];
   assign out_side = side_ff[NumW-1];

endmodule

/* rtl/core/barometer_compensation.sv */
// throughput: one word per cycle while no blocked output word stalls the pipe; the two
// dividers resolve one quotient bit per stage
// (27 stages for temperature, 33 for pressure) and set most of the latency
// reset: synchronous, clears every stage valid and loads the calibration defaults
module barometer_compensation (
   input logic        clock,
   input logic        reset,
   baro_chan_if.sink   req_if,
   baro_chan_if.source rsp_if,
   baro_chan_if.sink   csr_if
);
   import baro_pkg::*;

   // calibration registers
   logic [31:0] offset_ff, sens_ff, tcoef_ff, square_ff, curve_ff;
   logic [1:0]  oss_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         offset_ff <= OFFSET_COEFS_RESET;
         sens_ff   <= SENS_COEFS_RESET;
         tcoef_ff  <= TEMP_COEFS_RESET;
         square_ff <= SQUARE_COEFS_RESET;
         curve_ff  <= CURVE_COEFS_RESET;
         oss_ff    <= OVERSAMPLING_RESET;
      end else if (csr_if.valid) begin
         unique case (csr_if.payload.index)
            CSR_OFFSET_COEFS: offset_ff <= csr_if.payload.data;
            CSR_SENS_COEFS:   sens_ff   <= csr_if.payload.data;
            CSR_TEMP_COEFS:   tcoef_ff  <= csr_if.payload.data;
            CSR_SQUARE_COEFS: square_ff <= csr_if.payload.data;
            CSR_CURVE_COEFS:  curve_ff  <= csr_if.payload.data;
            CSR_OVERSAMPLING: oss_ff    <= csr_if.payload.data[1:0];
            default: ;
         endcase
      end
   end

   assign csr_if.ready = 1'b1;

   logic signed [15:0] ac1, ac2, ac3, b1, b2, mc, md;
   logic [15:0]        ac4, ac5, ac6;

   assign ac1 = $signed(offset_ff[31:16]);
   assign ac2 = $signed(offset_ff[15:0]);
   assign ac3 = $signed(sens_ff[31:16]);
   assign ac4 = sens_ff[15:0];
   assign ac5 = tcoef_ff[31:16];
   assign ac6 = tcoef_ff[15:0];
   assign b1  = $signed(square_ff[31:16]);
   assign b2  = $signed(square_ff[15:0]);
   assign mc  = $signed(curve_ff[31:16]);
   assign md  = $signed(curve_ff[15:0]);

   // flow control: the pipe moves unless its last stage is blocked by the output word
   logic s1_vld_ff, s2_vld_ff, sd_vld_ff, se_vld_ff, sf_vld_ff, sg_vld_ff, sh_vld_ff;
   logic sj_vld_ff, sk_vld_ff, rsp_vld_ff;
   logic out_free, pipe_en;
   logic d1_vld, d2_vld;

   assign out_free     = !rsp_vld_ff || rsp_if.ready;
   assign pipe_en      = !sk_vld_ff || out_free;
   assign req_if.ready = pipe_en;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff  <= 1'b0;
         s2_vld_ff  <= 1'b0;
         sd_vld_ff  <= 1'b0;
         se_vld_ff  <= 1'b0;
         sf_vld_ff  <= 1'b0;
         sg_vld_ff  <= 1'b0;
         sh_vld_ff  <= 1'b0;
         sj_vld_ff  <= 1'b0;
         sk_vld_ff  <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else begin
         if (pipe_en) begin
            s1_vld_ff <= req_if.valid;
            s2_vld_ff <= s1_vld_ff;
            sd_vld_ff <= d1_vld;
            se_vld_ff <= sd_vld_ff;
            sf_vld_ff <= se_vld_ff;
            sg_vld_ff <= sf_vld_ff;
            sh_vld_ff <= sg_vld_ff;
            sj_vld_ff <= d2_vld;
            sk_vld_ff <= sj_vld_ff;
         end
         if (out_free) begin
            rsp_vld_ff <= sk_vld_ff;
         end
      end
   end

   // stage 1: x1 = ((ut - ac6) * ac5) >> 15
   logic signed [16:0] s1_diff;
   logic signed [33:0] s1_prod;
   logic signed [18:0] s1_x1_in, s1_x1_ff;
   logic [18:0]        s1_up_ff;

   assign s1_diff  = $signed({1'b0, req_if.payload.raw_temp}) - $signed({1'b0, ac6});
   assign s1_prod  = s1_diff * $signed({1'b0, ac5});
   assign s1_x1_in = $signed(s1_prod[33:15]);

   // stage 2: divider operands as magnitudes
   logic signed [19:0] s2_den;
   logic signed [26:0] s2_num;
   logic [26:0]        s2_num_in, s2_num_ff;
   logic [17:0]        s2_den_in, s2_den_ff;
   tdiv_side_type      s2_side_in, s2_side_ff;

   assign s2_den    = 20'(s1_x1_ff) + 20'(md);
   assign s2_num    = $signed({mc, 11'b0});
   assign s2_num_in = s2_num[26] ? 27'(-s2_num) : 27'(s2_num);
   assign s2_den_in = s2_den[19] ? 18'(-s2_den) : 18'(s2_den);

   always_comb begin
      s2_side_in.x1    = s1_x1_ff;
      s2_side_in.up    = s1_up_ff;
      s2_side_in.dzero = (s2_den == '0);
      s2_side_in.neg   = mc[15] ^ s2_den[19];
   end

   // temperature divider: x2 = mc * 2048 / (x1 + md), toward zero
   logic [26:0]   d1_quo;
   tdiv_side_type d1_side;

   baro_div #(
      .NumW  (27),
      .DenW  (18),
      .SideW ($bits(tdiv_side_type))
   ) u_tdiv (
      .clock    (clock),
      .reset    (reset),
      .en       (pipe_en),
      .in_vld   (s2_vld_ff),
      .in_num   (s2_num_ff),
      .in_den   (s2_den_ff),
      .in_side  (s2_side_ff),
      .out_vld  (d1_vld),
      .out_quo  (d1_quo),
      .out_side (d1_side)
   );

   // stage d: b5, temperature, b6
   logic signed [27:0] sd_x2, sd_b5, sd_round;
   logic signed [23:0] sd_tfull;
   logic signed [15:0] sd_t_in, sd_t_ff;
   logic signed [27:0] sd_b6_in, sd_b6_ff;
   logic [18:0]        sd_up_ff;
   logic               sd_dzero_ff;

   assign sd_x2    = d1_side.neg ? -$signed({1'b0, d1_quo}) : $signed({1'b0, d1_quo});
   assign sd_b5    = 28'(d1_side.x1) + sd_x2;
   assign sd_round = sd_b5 + 28'sd8;
   assign sd_tfull = $signed(sd_round[27:4]);
   assign sd_b6_in = sd_b5 - B6_BIAS;

   always_comb begin
      priority if (sd_tfull > TEMP_MAX) sd_t_in = 16'(TEMP_MAX);
      else if (sd_tfull < TEMP_MIN)     sd_t_in = 16'(TEMP_MIN);
      else                              sd_t_in = 16'(sd_tfull);
   end

   // stage e: b6 squared and the linear products
   logic signed [55:0] se_sqfull;
   logic signed [43:0] se_sq_in, se_sq_ff;
   logic signed [43:0] se_pa_in, se_pa_ff, se_pc_in, se_pc_ff;
   logic signed [15:0] se_t_ff;
   logic [18:0]        se_up_ff;
   logic               se_dzero_ff;

   assign se_sqfull = sd_b6_ff * sd_b6_ff;
   assign se_sq_in  = $signed(se_sqfull[55:12]);
   assign se_pa_in  = ac2 * sd_b6_ff;
   assign se_pc_in  = ac3 * sd_b6_ff;

   // stage f: square terms
   logic signed [59:0] sf_m1_in, sf_m1_ff, sf_m2_in, sf_m2_ff;
   logic signed [43:0] sf_pa_ff, sf_pc_ff;
   logic signed [15:0] sf_t_ff;
   logic [18:0]        sf_up_ff;
   logic               sf_dzero_ff;

   assign sf_m1_in = b2 * se_sq_ff;
   assign sf_m2_in = b1 * se_sq_ff;

   // stage g: b3 and x3; only the low word survives the 32-bit wrap
   logic signed [33:0] sg_x3, sg_inner, sg_shift, sg_b3sum, sg_sumb;
   logic [31:0]        sg_b7a_in, sg_b7a_ff, sg_xb_in, sg_xb_ff;
   logic signed [15:0] sg_t_ff;
   logic               sg_dzero_ff;

   assign sg_x3     = $signed(sf_m1_ff[44:11]) + 34'($signed(sf_pa_ff[43:11]));
   assign sg_inner  = sg_x3 + 34'($signed({ac1, 2'b00}));
   assign sg_shift  = sg_inner <<< oss_ff;
   assign sg_b3sum  = sg_shift + 34'sd2;
   assign sg_b7a_in = {13'b0, sf_up_ff} - sg_b3sum[33:2];
   assign sg_sumb   = 34'($signed(sf_pc_ff[43:13])) + $signed(sf_m2_ff[49:16]) + 34'sd2;
   assign sg_xb_in  = sg_sumb[33:2] + B4_BIAS;

   // stage h: b4 and b7
   logic [47:0]        sh_b4_full, sh_b7_full;
   logic [15:0]        sh_scale;
   logic [16:0]        sh_b4_in, sh_b4_ff;
   logic [31:0]        sh_b7_in, sh_b7_ff;
   logic signed [15:0] sh_t_ff;
   logic               sh_dzero_ff;

   assign sh_b4_full = ac4 * sg_xb_ff;
   assign sh_b4_in   = sh_b4_full[31:15];
   assign sh_scale   = B7_SCALE >> oss_ff;
   assign sh_b7_full = sg_b7a_ff * sh_scale;
   assign sh_b7_in   = sh_b7_full[31:0];

   // pressure divider: doubles before dividing unless b7 has its top bit set
   logic          d2_hi;
   logic [32:0]   d2_num;
   pdiv_side_type d2_side_in, d2_side;
   logic [32:0]   d2_quo;

   assign d2_hi  = (sh_b7_ff >= B7_HALF);
   assign d2_num = d2_hi ? {1'b0, sh_b7_ff} : {sh_b7_ff, 1'b0};

   always_comb begin
      d2_side_in.temp = sh_t_ff;
      d2_side_in.err  = sh_dzero_ff || (sh_b4_ff == '0);
      d2_side_in.hi   = d2_hi;
   end

   baro_div #(
      .NumW  (33),
      .DenW  (17),
      .SideW ($bits(pdiv_side_type))
   ) u_pdiv (
      .clock    (clock),
      .reset    (reset),
      .en       (pipe_en),
      .in_vld   (sh_vld_ff),
      .in_num   (d2_num),
      .in_den   (sh_b4_ff),
      .in_side  (d2_side_in),
      .out_vld  (d2_vld),
      .out_quo  (d2_quo),
      .out_side (d2_side)
   );

   // stage j: p and (p >> 8)^2
   logic [32:0]        sj_p_in, sj_p_ff;
   logic [49:0]        sj_sq_in, sj_sq_ff;
   logic signed [15:0] sj_t_ff;
   logic               sj_err_ff;

   assign sj_p_in  = d2_side.hi ? {d2_quo[31:0], 1'b0} : d2_quo;
   assign sj_sq_in = sj_p_in[32:8] * sj_p_in[32:8];

   // stage k: correction terms
   logic [61:0]        sk_x1c_full;
   logic [45:0]        sk_x1c_in, sk_x1c_ff;
   logic signed [47:0] sk_x2c_full;
   logic signed [31:0] sk_x2c_in, sk_x2c_ff;
   logic [32:0]        sk_p_ff;
   logic signed [15:0] sk_t_ff;
   logic               sk_err_ff;

   assign sk_x1c_full = sj_sq_ff * P_SQ_GAIN;
   assign sk_x1c_in   = sk_x1c_full[61:16];
   assign sk_x2c_full = $signed({1'b0, sj_p_ff}) * P_LIN_GAIN;
   assign sk_x2c_in   = $signed(sk_x2c_full[47:16]);

   // output word
   logic signed [47:0] rsp_sum, rsp_pr;
   rsp_payload_type    rsp_data_in, rsp_data_ff;

   assign rsp_sum = $signed({2'b00, sk_x1c_ff}) + 48'(sk_x2c_ff) + P_OFFSET;
   assign rsp_pr  = $signed({15'b0, sk_p_ff}) + (rsp_sum >>> 4);

   always_comb begin
      rsp_data_in.temperature_dc = sk_t_ff;
      rsp_data_in.divide_error   = sk_err_ff;
      priority if (rsp_pr < 48'sd0) rsp_data_in.pressure_pa = '0;
      else if (rsp_pr > PRES_MAX)   rsp_data_in.pressure_pa = 20'(PRES_MAX);
      else                          rsp_data_in.pressure_pa = rsp_pr[19:0];
      if (sk_err_ff) begin
         rsp_data_in.temperature_dc = '0;
         rsp_data_in.pressure_pa    = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         s1_x1_ff    <= s1_x1_in;
         s1_up_ff    <= req_if.payload.raw_pressure;
         s2_num_ff   <= s2_num_in;
         s2_den_ff   <= s2_den_in;
         s2_side_ff  <= s2_side_in;
         sd_t_ff     <= sd_t_in;
         sd_b6_ff    <= sd_b6_in;
         sd_up_ff    <= d1_side.up;
         sd_dzero_ff <= d1_side.dzero;
         se_sq_ff    <= se_sq_in;
         se_pa_ff    <= se_pa_in;
         se_pc_ff    <= se_pc_in;
         se_t_ff     <= sd_t_ff;
         se_up_ff    <= sd_up_ff;
         se_dzero_ff <= sd_dzero_ff;
         sf_m1_ff    <= sf_m1_in;
         sf_m2_ff    <= sf_m2_in;
         sf_pa_ff    <= se_pa_ff;
         sf_pc_ff    <= se_pc_ff;
         sf_t_ff     <= se_t_ff;
         sf_up_ff    <= se_up_ff;
         sf_dzero_ff <= se_dzero_ff;
         sg_b7a_ff   <= sg_b7a_in;
         sg_xb_ff    <= sg_xb_in;
         sg_t_ff     <= sf_t_ff;
         sg_dzero_ff <= sf_dzero_ff;
         sh_b4_ff    <= sh_b4_in;
         sh_b7_ff    <= sh_b7_in;
         sh_t_ff     <= sg_t_ff;
         sh_dzero_ff <= sg_dzero_ff;
         sj_p_ff     <= sj_p_in;
         sj_sq_ff    <= sj_sq_in;
         sj_t_ff     <= d2_side.temp;
         sj_err_ff   <= d2_side.err;
         sk_x1c_ff   <= sk_x1c_in;
         sk_x2c_ff   <= sk_x2c_in;
         sk_p_ff     <= sj_p_ff;
         sk_t_ff     <= sj_t_ff;
         sk_err_ff   <= sj_err_ff;
      end
      if (out_free) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_if.valid   = rsp_vld_ff;
   assign rsp_if.payload = rsp_data_ff;

`ifndef NO_ASSERTIONS
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid && rsp_if.payload.divide_error |->
         rsp_if.payload.temperature_dc == '0 && rsp_if.payload.pressure_pa == '0)
      else $error("error word carries nonzero readings");

   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !req_if.ready |-> rsp_if.valid && !rsp_if.ready)
      else $error("input stalled without a blocked output word");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_if.valid)
      else $error("output word valid right after reset");
`endif

endmodule

/* test/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
   import baro_pkg::*;

   class baro_scoreboard;
      logic [31:0]     regs [6];
      rsp_payload_type expected_words [$];
      int              errors;
      int              words_checked;
      int              zero_div_seen;

      function new();
         regs[0] = OFFSET_COEFS_RESET;
         regs[1] = SENS_COEFS_RESET;
         regs[2] = TEMP_COEFS_RESET;
         regs[3] = SQUARE_COEFS_RESET;
         regs[4] = CURVE_COEFS_RESET;
         regs[5] = {30'd0, OVERSAMPLING_RESET};
         errors = 0;
         words_checked = 0;
         zero_div_seen = 0;
      endfunction

      function void write_reg(csr_idx_type idx, logic [31:0] data);
         // writes beyond the register map are dropped by the block
         if (idx <= CSR_OVERSAMPLING)
            regs[idx] = (idx == CSR_OVERSAMPLING) ? {30'd0, data[1:0]} : data;
      endfunction

      function rsp_payload_type compensate(req_payload_type r);
         rsp_payload_type o;
         longint ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
         longint ut, upl, den, x1, x2, x3, b3, b5, b6, t, sq, pl, pr;
         longint unsigned p;
         logic [31:0] b4, b7, diff, tmp;
         int oss;
         ac1 = longint'($signed(regs[0][31:16]));
         ac2 = longint'($signed(regs[0][15:0]));
         ac3 = longint'($signed(regs[1][31:16]));
         ac4 = longint'(regs[1][15:0]);
         ac5 = longint'(regs[2][31:16]);
         ac6 = longint'(regs[2][15:0]);
         b1  = longint'($signed(regs[3][31:16]));
         b2  = longint'($signed(regs[3][15:0]));
         mc  = longint'($signed(regs[4][31:16]));
         md  = longint'($signed(regs[4][15:0]));
         oss = int'(regs[5][1:0]);
         ut  = longint'(r.raw_temp);
         upl = longint'(r.raw_pressure);
         o = '0;
         x1 = ((ut - ac6) * ac5) >>> 15;
         den = x1 + md;
         if (den == 0) begin
            o.divide_error = 1'b1;
            return o;
         end
         x2 = (mc * 2048) / den;
         b5 = x1 + x2;
         t = (b5 + 8) >>> 4;
         b6 = b5 - 4000;
         sq = (b6 * b6) >>> 12;
         x1 = (b2 * sq) >>> 11;
         x2 = (ac2 * b6) >>> 11;
         x3 = x1 + x2;
         b3 = ((ac1 * 4 + x3) * (longint'(1) << oss) + 2) >>> 2;
         x1 = (ac3 * b6) >>> 13;
         x2 = (b1 * sq) >>> 16;
         x3 = (x1 + x2 + 2) >>> 2;
         tmp = 32'(x3 + 32768);
         b4 = 32'(ac4 * longint'(tmp)) >> 15;
         if (b4 == 0) begin
            o.divide_error = 1'b1;
            return o;
         end
         diff = 32'(upl - b3);
         b7 = 32'(longint'(diff) * longint'(50000 >> oss));
         if (b7 < 32'h8000_0000)
            p = (longint'(b7) * 2) / longint'(b4);
         else
            p = (longint'(b7) / longint'(b4)) * 2;
         pl = longint'(p);
         x1 = (pl >> 8) * (pl >> 8);
         x1 = (x1 * 3038) >>> 16;
         x2 = (-7357 * pl) >>> 16;
         pr = pl + ((x1 + x2 + 3791) >>> 4);
         if (t > 32767) t = 32767;
         if (t < -32768) t = -32768;
         if (pr > 1048575) pr = 1048575;
         if (pr < 0) pr = 0;
         o.temperature_dc = 16'(t);
         o.pressure_pa = 20'(pr);
         return o;
      endfunction

      function void note_reading(req_payload_type r);
         expected_words.push_back(compensate(r));
      endfunction

      function void check_word(rsp_payload_type w);
         rsp_payload_type e;
         if (expected_words.size() == 0) begin
            $error("result word with nothing pending");
            errors++;
            return;
         end
         e = expected_words.pop_front();
         words_checked++;
         if (w.divide_error) zero_div_seen++;
         if (w.temperature_dc !== e.temperature_dc) begin
            $error("temperature_dc expected %0d got %0d", e.temperature_dc, w.temperature_dc);
            errors++;
         end
         if (w.pressure_pa !== e.pressure_pa) begin
            $error("pressure_pa expected %0d got %0d", e.pressure_pa, w.pressure_pa);
            errors++;
         end
         if (w.divide_error !== e.divide_error) begin
            $error("divide_error expected %0d got %0d", e.divide_error, w.divide_error);
            errors++;
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;

   baro_chan_if #(.payload_type(req_payload_type)) req_if ();
   baro_chan_if #(.payload_type(rsp_payload_type)) rsp_if ();
   baro_chan_if #(.payload_type(csr_payload_type)) csr_if ();

   barometer_compensation dut (
      .clock (clock),
      .reset (reset),
      .req_if(req_if),
      .rsp_if(rsp_if),
      .csr_if(csr_if)
   );

   always #6 clock = ~clock;

   baro_scoreboard sb = new();
   int  burst_left = 0;
   int  readings_sent = 0;
   int  csr_writes = 0;
   int  idle_cycles = 0;
   bit  hold_off = 1'b0;

   initial begin
      req_if.valid = 1'b0;
      req_if.payload = '0;
      rsp_if.ready = 1'b0;
      csr_if.valid = 1'b0;
      csr_if.payload = '0;
   end

   always @(posedge clock) begin
      if (!reset && rsp_if.valid && rsp_if.ready)
         sb.check_word(rsp_if.payload);
   end

   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) ||
          (csr_if.valid && csr_if.ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= 3000) begin
            $display("watchdog: no handshake for %0d cycles", idle_cycles);
            $display("tb_top NOT OK");
            $finish;
         end
      end
   end

   // receiver: stall pattern picked at random from four modes, with occasional long holds
   initial begin
      int cyc;
      int mode;
      cyc = 0;
      mode = 0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (hold_off) begin
            rsp_if.ready = 1'b0;
            repeat (400) @(negedge clock);
            hold_off = 1'b0;
         end
         cyc++;
         if (cyc % 250 == 0) mode = $urandom_range(0, 3);
         case (mode)
            0: rsp_if.ready = 1'b1;
            1: rsp_if.ready = $urandom_range(0, 1);
            2: rsp_if.ready = ($urandom_range(0, 7) != 0);
            default: rsp_if.ready = (cyc % 4 != 0);
         endcase
         @(negedge clock);
      end
   end

   task automatic push_reading(logic [15:0] ut, logic [18:0] up);
      if (burst_left == 0) begin
         req_if.valid = 1'b0;
         if ($urandom_range(0, 3) != 0) repeat ($urandom_range(1, 12)) @(negedge clock);
         burst_left = $urandom_range(1, 40);
      end
      req_if.valid = 1'b1;
      req_if.payload.raw_temp = ut;
      req_if.payload.raw_pressure = up;
      do @(posedge clock); while (!req_if.ready);
      sb.note_reading(req_if.payload);
      readings_sent++;
      burst_left--;
      @(negedge clock);
   endtask

   task automatic settle();
      req_if.valid = 1'b0;
      burst_left = 0;
      while (sb.expected_words.size() != 0) @(negedge clock);
      repeat (80) @(negedge clock);
   endtask

   task automatic write_csr(csr_idx_type idx, logic [31:0] data);
      csr_if.valid = 1'b1;
      csr_if.payload.index = idx;
      csr_if.payload.data = data;
      do @(posedge clock); while (!csr_if.ready);
      sb.write_reg(idx, data);
      csr_writes++;
      @(negedge clock);
      csr_if.valid = 1'b0;
   endtask

   task automatic load_coefs(logic [31:0] c0, logic [31:0] c1, logic [31:0] c2,
                             logic [31:0] c3, logic [31:0] c4, logic [1:0] oss);
      settle();
      write_csr(CSR_OFFSET_COEFS, c0);
      write_csr(CSR_SENS_COEFS, c1);
      write_csr(CSR_TEMP_COEFS, c2);
      write_csr(CSR_SQUARE_COEFS, c3);
      write_csr(CSR_CURVE_COEFS, c4);
      write_csr(CSR_OVERSAMPLING, {30'd0, oss});
   endtask

   // realistic readings most of the time, full-range noise otherwise
   task automatic random_readings(int n);
      repeat (n) begin
         if ($urandom_range(0, 3) != 0)
            push_reading(16'($urandom_range(20000, 36000)), 19'($urandom_range(10000, 400000)));
         else
            push_reading(16'($urandom), 19'($urandom));
      end
   endtask

   initial begin
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed, reset calibration
      push_reading(16'd0, 19'd0);
      push_reading(16'hffff, 19'h7ffff);
      push_reading(16'd0, 19'h7ffff);
      push_reading(16'hffff, 19'd0);
      push_reading(16'd27898, 19'd23843);
      push_reading(16'd27898, 19'd47686);
      push_reading(16'd32768, 19'd262144);
      push_reading(16'd1, 19'd1);

      // all zero: temperature divisor is zero
      load_coefs('0, '0, '0, '0, '0, 2'd0);
      push_reading(16'd0, 19'd0);
      push_reading(16'hffff, 19'h7ffff);
      // AC4 zero: pressure divisor is zero
      load_coefs(OFFSET_COEFS_RESET, {SENS_COEFS_RESET[31:16], 16'd0}, TEMP_COEFS_RESET,
                 SQUARE_COEFS_RESET, CURVE_COEFS_RESET, 2'd3);
      push_reading(16'd27898, 19'd23843);
      push_reading(16'hffff, 19'h7ffff);
      // all ones, widest shift
      load_coefs('1, '1, '1, '1, '1, 2'd3);
      push_reading(16'd0, 19'd0);
      push_reading(16'hffff, 19'h7ffff);
      push_reading(16'h8000, 19'h40000);
      // extreme coefficients that push the outputs into saturation
      load_coefs(32'h7fff_8000, 32'h8000_ffff, 32'hffff_0000, 32'h7fff_7fff, 32'h7fff_0001, 2'd0);
      push_reading(16'hffff, 19'h7ffff);
      push_reading(16'd0, 19'd0);
      push_reading(16'd100, 19'h7ffff);

      // writes past the register map change nothing
      settle();
      write_csr(3'd6, 32'hdead_beef);
      write_csr(3'd7, 32'hffff_ffff);
      push_reading(16'd12345, 19'd54321);

      // random part across several settings
      for (int ph = 0; ph < 8; ph++) begin
         case (ph)
            0: load_coefs(OFFSET_COEFS_RESET, SENS_COEFS_RESET, TEMP_COEFS_RESET,
                          SQUARE_COEFS_RESET, CURVE_COEFS_RESET, 2'd0);
            1: load_coefs(OFFSET_COEFS_RESET, SENS_COEFS_RESET, TEMP_COEFS_RESET,
                          SQUARE_COEFS_RESET, CURVE_COEFS_RESET, 2'd3);
            2, 3: load_coefs(OFFSET_COEFS_RESET ^ 32'($urandom_range(0, 255)),
                             SENS_COEFS_RESET ^ 32'($urandom_range(0, 255)),
                             TEMP_COEFS_RESET ^ 32'($urandom_range(0, 255)),
                             SQUARE_COEFS_RESET ^ 32'($urandom_range(0, 255)),
                             CURVE_COEFS_RESET ^ 32'($urandom_range(0, 255)),
                             2'($urandom));
            default: load_coefs($urandom, $urandom, $urandom, $urandom, $urandom, 2'($urandom));
         endcase
         if (ph == 2) begin
            random_readings(50);
            hold_off = 1'b1;
            random_readings(150);
         end else if (ph == 5) begin
            random_readings(100);
            req_if.valid = 1'b0;
            burst_left = 0;
            while (sb.expected_words.size() != 0) @(negedge clock);
            random_readings(100);
         end else begin
            random_readings(200);
         end
      end

      settle();
      repeat (20) @(negedge clock);
      if (sb.expected_words.size() != 0) begin
         $error("%0d result words never arrived", sb.expected_words.size());
         sb.errors++;
      end
      $display("%0d readings, %0d words checked, %0d with divide error, %0d register writes",
               readings_sent, sb.words_checked, sb.zero_div_seen, csr_writes);
      $display("settings covered: reset, zero, all ones, saturating, near default, random");
      if (sb.errors == 0) begin
         $display("tb_top OK");
      end else begin
         $display("tb_top NOT OK");
      end
      $finish;
   end

endmodule

/* filelist.f */
rtl/core/baro_pkg.sv
rtl/core/baro_chan_if.sv
rtl/core/baro_div.sv
rtl/core/barometer_compensation.sv
test/tb_top.sv
